>>> rtl/euler_to_quaternion_assert.svh
// ----------------------------------------------------------------------------
// euler_to_quaternion assertion macros
// Shared forms for the concurrent checks of the conversion block.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// same-cycle implication, disabled during reset
`define E2Q_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("e2q check failed");

// next-cycle implication, disabled during reset
`define E2Q_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("e2q check failed");

`endif

>>> rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Types, widths and constants of the Euler angle to quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int LANES        = 3;        // roll, pitch, yaw
    localparam int ANGLE_W      = 16;
    localparam int OUT_W        = 16;
    localparam int RED_W        = ANGLE_W + 1;
    localparam int MAG_W        = 14;       // folded half angle magnitude
    localparam int DEG_W        = 34;
    localparam int ZMAG_W       = 32;
    localparam int CW           = 33;       // CORDIC x, y, z datapath
    localparam int SC_W         = 22;       // Q20 sine / cosine incl. +1 and sign
    localparam int MAX_STAGES   = 24;
    localparam int STAGES_DEF   = 16;

    localparam logic signed [RED_W-1:0] HALF_TURN    = 17'sd23040;
    localparam logic signed [RED_W-1:0] FULL_TURN    = 17'sd46080;
    localparam logic signed [RED_W-1:0] QUARTER_TURN = 17'sd11520;

    localparam logic [DEG_W-1:0]        DEG_RAD_Q46  = 34'd9595049034;
    localparam logic signed [CW-1:0]    CORDIC_ONE   = 33'sh26DD3B6A;

    localparam logic [31:0] ATAN_Q30 [MAX_STAGES] = '{
        32'h3243F6A9, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h00100000, 32'h00080000,
        32'h00040000, 32'h00020000, 32'h00010000, 32'h00008000,
        32'h00004000, 32'h00002000, 32'h00001000, 32'h00000800,
        32'h00000400, 32'h00000200, 32'h00000100, 32'h00000080
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg_cos;
    } t_lane;

    typedef struct packed {
        logic              valid;
        t_lane [LANES-1:0] lane;
    } t_stage;

endpackage

>>> rtl/e2q_prep.sv
// ----------------------------------------------------------------------------
// e2q_prep
// Reduces each half angle to a quarter turn and scales it to Q30 radians.
// ----------------------------------------------------------------------------
module e2q_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  i_angle [e2q_pkg::LANES],
    output e2q_pkg::t_stage                     o_stage
);
    import e2q_pkg::*;

    logic signed [RED_W-1:0]        w_wrap [LANES];
    logic signed [RED_W-1:0]        w_fold [LANES];
    logic                           w_ncos [LANES];
    logic signed [RED_W-1:0]        w_abs  [LANES];
    logic [MAG_W+DEG_W-1:0]         w_prod [LANES];
    logic [MAG_W+DEG_W-1:0]         w_rnd  [LANES];
    logic signed [CW-1:0]           w_zmag [LANES];

    logic                           r_v1;
    logic [MAG_W-1:0]               r_mag  [LANES];
    logic                           r_neg  [LANES];
    logic                           r_ncos [LANES];
    t_stage                         r_stage;
    t_stage                         n_stage;

    // stage 1: wrap into [-180, 180), fold into [-90, 90]
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_wrap[l] = RED_W'(i_angle[l]);
            if (w_wrap[l] >= HALF_TURN) begin
                w_wrap[l] = w_wrap[l] - FULL_TURN;
            end else if (w_wrap[l] < -HALF_TURN) begin
                w_wrap[l] = w_wrap[l] + FULL_TURN;
            end
            w_fold[l] = w_wrap[l];
            w_ncos[l] = 1'b0;
            if (w_wrap[l] > QUARTER_TURN) begin
                w_fold[l] = HALF_TURN - w_wrap[l];
                w_ncos[l] = 1'b1;
            end else if (w_wrap[l] < -QUARTER_TURN) begin
                w_fold[l] = -HALF_TURN - w_wrap[l];
                w_ncos[l] = 1'b1;
            end
            w_abs[l] = w_fold[l][RED_W-1] ? -w_fold[l] : w_fold[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_mag[l]  <= w_abs[l][MAG_W-1:0];
                r_neg[l]  <= w_fold[l][RED_W-1];
                r_ncos[l] <= w_ncos[l];
            end
        end
    end

    // stage 2: magnitude times pi/23040 in Q46, round to Q30, sign back on
    always_comb begin
        n_stage.valid = r_v1;
        for (int l = 0; l < LANES; l++) begin
            w_prod[l] = {{DEG_W{1'b0}}, r_mag[l]} * {{MAG_W{1'b0}}, DEG_RAD_Q46};
            w_rnd[l]  = w_prod[l] + (MAG_W+DEG_W)'(32768);
            w_zmag[l] = $signed({1'b0, w_rnd[l][ZMAG_W+15:16]});
            n_stage.lane[l].x       = CORDIC_ONE;
            n_stage.lane[l].y       = '0;
            n_stage.lane[l].z       = r_neg[l] ? -w_zmag[l] : w_zmag[l];
            n_stage.lane[l].neg_cos = r_ncos[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> rtl/e2q_cordic_cell.sv
// ----------------------------------------------------------------------------
// e2q_cordic_cell
// One CORDIC rotation step for all three angles, registered.
// ----------------------------------------------------------------------------
module e2q_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  e2q_pkg::t_stage i_stage,
    output e2q_pkg::t_stage o_stage
);
    import e2q_pkg::*;

    localparam logic signed [CW-1:0] ATAN = $signed({1'b0, ATAN_Q30[IDX]});

    logic signed [CW-1:0] w_x  [LANES];
    logic signed [CW-1:0] w_y  [LANES];
    logic signed [CW-1:0] w_z  [LANES];
    t_stage               n_stage;
    t_stage               r_stage;

    always_comb begin
        n_stage.valid = i_stage.valid;
        for (int l = 0; l < LANES; l++) begin
            w_x[l] = i_stage.lane[l].x;
            w_y[l] = i_stage.lane[l].y;
            w_z[l] = i_stage.lane[l].z;
            n_stage.lane[l].neg_cos = i_stage.lane[l].neg_cos;
            if (!w_z[l][CW-1]) begin
                n_stage.lane[l].x = w_x[l] - (w_y[l] >>> IDX);
                n_stage.lane[l].y = w_y[l] + (w_x[l] >>> IDX);
                n_stage.lane[l].z = w_z[l] - ATAN;
            end else begin
                n_stage.lane[l].x = w_x[l] + (w_y[l] >>> IDX);
                n_stage.lane[l].y = w_y[l] - (w_x[l] >>> IDX);
                n_stage.lane[l].z = w_z[l] + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> rtl/e2q_combine.sv
// ----------------------------------------------------------------------------
// e2q_combine
// Rounds sine/cosine to Q20 and forms the four quaternion components.
// ----------------------------------------------------------------------------
module e2q_combine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  e2q_pkg::t_stage                    i_stage,
    output logic                               o_valid,
    output logic signed [e2q_pkg::OUT_W-1:0]   o_w,
    output logic signed [e2q_pkg::OUT_W-1:0]   o_x,
    output logic signed [e2q_pkg::OUT_W-1:0]   o_y,
    output logic signed [e2q_pkg::OUT_W-1:0]   o_z
);
    import e2q_pkg::*;

    localparam int P2_W = 2 * SC_W;
    localparam int P3_W = 3 * SC_W;
    localparam int QW   = P3_W - 46;

    localparam logic signed [CW-1:0]   Q20_P = CW'(1 << 20);
    localparam logic signed [CW-1:0]   Q20_N = -Q20_P;
    localparam logic signed [P3_W-1:0] HALF_LSB = P3_W'(64'sd1 <<< 45);
    localparam logic signed [QW-1:0]   ONE_P  = QW'(16384);
    localparam logic signed [QW-1:0]   ONE_N  = -ONE_P;

    logic signed [CW-1:0]   w_cx [LANES];
    logic signed [CW-1:0]   w_sx [LANES];
    logic signed [SC_W-1:0] w_c  [LANES];
    logic signed [SC_W-1:0] w_s  [LANES];

    logic                   r_v1, r_v2, r_v3, r_v4;
    logic signed [SC_W-1:0] r_c  [LANES];
    logic signed [SC_W-1:0] r_s  [LANES];
    logic signed [P2_W-1:0] r_cc, r_ss, r_sc, r_cs;
    logic signed [SC_W-1:0] r_cy, r_sy;
    logic signed [P3_W-1:0] r_p  [8];
    logic signed [P3_W-1:0] w_sum [4];
    logic signed [QW-1:0]   w_q   [4];
    logic signed [OUT_W-1:0] w_o  [4];
    logic signed [OUT_W-1:0] r_o  [4];

    // Q30 -> Q20, round half up, clamp to +-1, cosine sign from the fold
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_cx[l] = (i_stage.lane[l].x + CW'(512)) >>> 10;
            w_sx[l] = (i_stage.lane[l].y + CW'(512)) >>> 10;
            if (w_cx[l] > Q20_P)      w_cx[l] = Q20_P;
            else if (w_cx[l] < Q20_N) w_cx[l] = Q20_N;
            if (w_sx[l] > Q20_P)      w_sx[l] = Q20_P;
            else if (w_sx[l] < Q20_N) w_sx[l] = Q20_N;
            w_c[l] = i_stage.lane[l].neg_cos ? -w_cx[l][SC_W-1:0] : w_cx[l][SC_W-1:0];
            w_s[l] = w_sx[l][SC_W-1:0];
        end
    end

    // sums of triple products, round to Q14, saturate
    always_comb begin
        w_sum[0] = r_p[0] + r_p[1];
        w_sum[1] = r_p[2] - r_p[3];
        w_sum[2] = r_p[4] + r_p[5];
        w_sum[3] = r_p[6] - r_p[7];
        for (int k = 0; k < 4; k++) begin
            w_q[k] = QW'((w_sum[k] + HALF_LSB) >>> 46);
            if (w_q[k] > ONE_P)      w_o[k] = ONE_P[OUT_W-1:0];
            else if (w_q[k] < ONE_N) w_o[k] = ONE_N[OUT_W-1:0];
            else                     w_o[k] = w_q[k][OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_stage.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (i_en) begin
            r_c  <= w_c;
            r_s  <= w_s;
            // lane 0 roll, 1 pitch, 2 yaw
            r_cc <= r_c[0] * r_c[1];
            r_ss <= r_s[0] * r_s[1];
            r_sc <= r_s[0] * r_c[1];
            r_cs <= r_c[0] * r_s[1];
            r_cy <= r_c[2];
            r_sy <= r_s[2];
            r_p[0] <= r_cc * r_cy;
            r_p[1] <= r_ss * r_sy;
            r_p[2] <= r_sc * r_cy;
            r_p[3] <= r_cs * r_sy;
            r_p[4] <= r_cs * r_cy;
            r_p[5] <= r_sc * r_sy;
            r_p[6] <= r_cc * r_sy;
            r_p[7] <= r_ss * r_cy;
            r_o  <= w_o;
        end
    end

    assign o_valid = r_v4;
    assign o_w     = r_o[0];
    assign o_x     = r_o[1];
    assign o_y     = r_o[2];
    assign o_z     = r_o[3];

endmodule

>>> rtl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Roll/pitch/yaw in 1/64 degree to a unit quaternion in signed Q1.14.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_roll_angle, i_pitch_angle and
// i_yaw_angle. A transfer happens on a rising edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall with o_out_w .. o_out_z,
// transferred on an edge with o_valid high and i_stall low.
// The pipeline registers angle reduction, then radian scaling, then each
// CORDIC rotation cell in turn, and then rounding, pair products, triple
// products and final sum/saturate. Throughput is one transfer per cycle
// unless the receiver stalls; the chain of rotation cells and the product
// stages all advance together on one enable.
// When the receiver stalls while a result waits, the whole pipeline freezes
// and o_stall goes high; bubbles inside the pipeline also hold their place.
// Synchronous reset clears every valid bit; data registers are not reset.
// The block holds no state between transfers.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_assert.svh"

module euler_to_quaternion #(
    parameter int CORDIC_STAGES = e2q_pkg::STAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] i_roll_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] i_pitch_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] i_yaw_angle,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [e2q_pkg::OUT_W-1:0]   o_out_w,
    output logic signed [e2q_pkg::OUT_W-1:0]   o_out_x,
    output logic signed [e2q_pkg::OUT_W-1:0]   o_out_y,
    output logic signed [e2q_pkg::OUT_W-1:0]   o_out_z
);
    import e2q_pkg::*;

    // single pipeline enable: move unless a finished result is held
    logic                       w_en;
    logic signed [ANGLE_W-1:0]  w_angle [LANES];
    t_stage                     w_stage [CORDIC_STAGES+1];

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // lane order is fixed everywhere: roll, pitch, yaw
    assign w_angle[0] = i_roll_angle;
    assign w_angle[1] = i_pitch_angle;
    assign w_angle[2] = i_yaw_angle;

    e2q_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_angle (w_angle),
        .o_stage (w_stage[0])
    );

    // chain of rotation cells, cell i shifts by i and uses atan(2^-i)
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        e2q_cordic_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    e2q_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_stage (w_stage[CORDIC_STAGES]),
        .o_valid (o_valid),
        .o_w     (o_out_w),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_z     (o_out_z)
    );

    // results never leave the saturation window
    `E2Q_ASSERT_IMPL(a_out_range, i_clk, i_rst_n, o_valid, (o_out_w <= 16'sd16384) && (o_out_w >= -16'sd16384) && (o_out_x <= 16'sd16384) && (o_out_x >= -16'sd16384) && (o_out_y <= 16'sd16384) && (o_out_y >= -16'sd16384) && (o_out_z <= 16'sd16384) && (o_out_z >= -16'sd16384))

    // an accepted transfer reaches the head of the cell chain once both prep registers have advanced
    `E2Q_ASSERT_NEXT(a_prep_valid, i_clk, i_rst_n, (i_valid && !o_stall) ##1 !o_stall, w_stage[0].valid)

endmodule

>>> tb/euler_to_quaternion_tb.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_tb
// Streams roll/pitch/yaw triples into the converter under random source gaps
// and sink stalls. A bit-exact software CORDIC model predicts each quaternion,
// and every output transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module euler_to_quaternion_tb;

    localparam int STAGES      = 16;
    localparam int LATENCY     = STAGES + 6;
    localparam int N_RANDOM    = 1030;
    localparam int MAX_GAP     = 13;
    localparam int LONG_HOLD   = 120;      // sink hold-off that backs the pipe up
    localparam int IDLE_LIMIT  = 4000;     // cycles without any transfer
    localparam int MAX_REPORTS = 10;

    typedef logic signed [e2q_pkg::ANGLE_W-1:0] angle_t;
    typedef logic signed [e2q_pkg::OUT_W-1:0]   comp_t;

    // one input transfer plus the source-side pacing that goes with it
    typedef struct {
        angle_t      roll;
        angle_t      pitch;
        angle_t      yaw;
        int unsigned gap;      // idle cycles before offering
        bit          drain;    // hold until every outstanding result is back
    } euler_t;

    typedef struct {
        comp_t w;
        comp_t x;
        comp_t y;
        comp_t z;
    } quat_t;

    // DUT signals; every input is known from time zero
    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   i_valid       = 1'b0;
    logic   o_stall;
    angle_t i_roll_angle  = '0;
    angle_t i_pitch_angle = '0;
    angle_t i_yaw_angle   = '0;
    logic   o_valid;
    logic   i_stall       = 1'b0;
    comp_t  o_out_w;
    comp_t  o_out_x;
    comp_t  o_out_y;
    comp_t  o_out_z;

    euler_t euler_q[$];        // angles not yet offered
    quat_t  quat_pending[$];   // predicted quaternions in flight, oldest first

    euler_t drv_item = '{default: 0};
    bit     drv_busy = 1'b0;
    bit     drv_offer;
    int     n_sent   = 0;      // input transfers (source process only)
    int     n_recv   = 0;      // output transfers, updated with NBA
    int     n_fail   = 0;

    euler_to_quaternion #(
        .CORDIC_STAGES (STAGES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_roll_angle  (i_roll_angle),
        .i_pitch_angle (i_pitch_angle),
        .i_yaw_angle   (i_yaw_angle),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_w       (o_out_w),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic longint clamp_q20(input longint v);
        if (v > 64'sd1048576) return 64'sd1048576;
        if (v < -64'sd1048576) return -64'sd1048576;
        return v;
    endfunction

    // Sine and cosine (Q20) of half the input angle. The raw 1/64 degree
    // input is already the half angle in 1/128 degree, so no shift needed.
    function automatic void half_angle_trig(input angle_t raw, output longint s_q20,
                                            output longint c_q20);
        longint h;
        longint mag;
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        int     k;
        h    = raw;
        flip = 1'b0;
        // wrap into [-180, 180) degrees of half angle
        if (h >= e2q_pkg::HALF_TURN) h -= e2q_pkg::FULL_TURN;
        if (h < -e2q_pkg::HALF_TURN) h += e2q_pkg::FULL_TURN;
        // fold into [-90, 90]; cosine changes sign, sine does not
        if (h > e2q_pkg::QUARTER_TURN) begin
            h    = e2q_pkg::HALF_TURN - h;
            flip = 1'b1;
        end else if (h < -e2q_pkg::QUARTER_TURN) begin
            h    = -e2q_pkg::HALF_TURN - h;
            flip = 1'b1;
        end
        // magnitude to Q30 radians, rounded half up, sign applied after
        mag = (h < 0) ? -h : h;
        z   = (mag * longint'(e2q_pkg::DEG_RAD_Q46) + 64'sd32768) >>> 16;
        if (h < 0) z = -z;
        x = e2q_pkg::CORDIC_ONE;
        y = 0;
        for (k = 0; k < STAGES; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - longint'(e2q_pkg::ATAN_Q30[k]);
            end else begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + longint'(e2q_pkg::ATAN_Q30[k]);
            end
            x = nx;
        end
        x     = clamp_q20((x + 512) >>> 10);
        y     = clamp_q20((y + 512) >>> 10);
        c_q20 = flip ? -x : x;
        s_q20 = y;
    endfunction

    // Q60 triple-product sum to Q14, round half up, saturate to +-1.0
    function automatic comp_t round_q14(input longint v);
        longint q;
        q = (v + (64'sd1 <<< 45)) >>> 46;
        if (q > 64'sd16384) q = 64'sd16384;
        if (q < -64'sd16384) q = -64'sd16384;
        return comp_t'(q);
    endfunction

    function automatic quat_t predict_quat(input euler_t e);
        longint sr, cr, sp, cp, sy, cy;
        quat_t  q;
        half_angle_trig(e.roll, sr, cr);
        half_angle_trig(e.pitch, sp, cp);
        half_angle_trig(e.yaw, sy, cy);
        q.w = round_q14(cr * cp * cy + sr * sp * sy);
        q.x = round_q14(sr * cp * cy - cr * sp * sy);
        q.y = round_q14(cr * sp * cy + sr * cp * sy);
        q.z = round_q14(cr * cp * sy - sr * sp * cy);
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_angles(input int r, input int p, input int y,
                              input int unsigned gap, input bit drain);
        euler_t e;
        e.roll  = angle_t'(r);
        e.pitch = angle_t'(p);
        e.yaw   = angle_t'(y);
        e.gap   = gap;
        e.drain = drain;
        euler_q.push_back(e);
    endtask

    // Mostly the stated +-360 degree range, with some full 16-bit codes,
    // tiny angles around zero and points near multiples of 90 degrees.
    function automatic int rand_angle();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return int'($urandom_range(0, 128)) - 64;
            2: return int'($urandom_range(0, 8)) * 5760 - 23040
                      + int'($urandom_range(0, 4)) - 2;
            default: return int'($urandom_range(0, 46080)) - 23040;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Source: one item at a time from euler_q. Valid stays up until the
    // transfer; the payload does not move while stalled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                // transfer at this edge: prediction joins the in-flight list
                quat_pending.push_back(predict_quat(drv_item));
                n_sent++;
                drv_busy = 1'b0;
            end
            if (!drv_busy && euler_q.size() != 0) begin
                drv_item = euler_q.pop_front();
                drv_busy = 1'b1;
            end
            // n_recv is the pre-edge value, so this does not race the sink
            if (drv_busy && drv_item.drain && n_recv != n_sent) begin
                drv_offer = 1'b0;
            end else if (drv_busy && drv_item.gap != 0) begin
                drv_item.gap--;
                drv_offer = 1'b0;
            end else begin
                drv_offer = drv_busy;
            end
            i_valid       <= drv_offer;
            i_roll_angle  <= drv_item.roll;
            i_pitch_angle <= drv_item.pitch;
            i_yaw_angle   <= drv_item.yaw;
        end
    end

    // ------------------------------------------------------------------------
    // Sink stall pattern: a random wait after every result, stretches with
    // no waits at all, and two long hold-offs that freeze the pipe and
    // push o_stall back to the source.
    // ------------------------------------------------------------------------
    int  rx_count = 0;
    int  rx_gap   = 0;
    int  rx_hold  = 0;
    bit  rx_fast  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                rx_count++;
                if (rx_count % 64 == 0) rx_fast = ($urandom_range(0, 2) == 0);
                rx_gap = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
                if (rx_count == 150 || rx_count == 650) rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check against the oldest prediction
    // ------------------------------------------------------------------------
    quat_t want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_recv <= n_recv + 1;
            if (quat_pending.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("[%0t] result with nothing pending: w=%0d x=%0d y=%0d z=%0d",
                             $realtime, o_out_w, o_out_x, o_out_y, o_out_z);
            end else begin
                want = quat_pending.pop_front();
                if (o_out_w !== want.w || o_out_x !== want.x ||
                    o_out_y !== want.y || o_out_z !== want.z) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("[%0t] mismatch exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                                 $realtime, want.w, want.x, want.y, want.z,
                                 o_out_w, o_out_x, o_out_y, o_out_z);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: gives up after a long run with no transfer on either side
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of test
    // ------------------------------------------------------------------------
    initial begin
        int k;
        bit burst;
        int unsigned gap;
        burst = 1'b0;

        // directed: zero rotation, the half-turn edges, the 16-bit extremes
        // that wrap around, the fold points at a quarter turn of half angle,
        // gimbal lock at pitch +-90 degrees, and tiny angles
        add_angles(0, 0, 0, 0, 1'b0);
        add_angles(23040, 0, 0, 0, 1'b0);
        add_angles(-23040, 0, 0, 0, 1'b0);
        add_angles(0, 23040, 0, 2, 1'b0);
        add_angles(0, 0, -23040, 0, 1'b0);
        add_angles(32767, -32768, 0, 0, 1'b0);
        add_angles(-32768, 32767, 32767, 5, 1'b0);
        add_angles(11520, -11520, 11521, 0, 1'b0);
        add_angles(-11521, 11519, -11519, 0, 1'b0);
        add_angles(23039, -23039, 23041, 1, 1'b0);
        add_angles(-23041, 0, 5760, 0, 1'b0);
        add_angles(0, 5760, 0, 0, 1'b0);
        add_angles(0, -5760, 0, 0, 1'b0);
        add_angles(5760, 5760, 5760, 3, 1'b0);
        add_angles(-5760, -5760, -5760, 0, 1'b0);
        add_angles(2880, -2880, 1440, 0, 1'b0);
        add_angles(1, -1, 1, 0, 1'b0);
        add_angles(-1, 1, -1, 0, 1'b0);
        add_angles(17280, -17280, 8640, 0, 1'b0);
        add_angles(-17280, 17280, -8640, 13, 1'b0);

        // random: gap drawn per item, with zero-gap bursts in between;
        // a few items wait for the pipe to drain completely first
        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            add_angles(rand_angle(), rand_angle(), rand_angle(), gap,
                       (k == 0 || k == 400 || k == 800));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample on the falling edge, away from the clocked processes
        do @(negedge i_clk);
        while (drv_busy || euler_q.size() != 0 || quat_pending.size() != 0);

        // tail: catch any stray result after the last expected one
        repeat (LATENCY + 8) @(negedge i_clk);
        n_fail += quat_pending.size();

        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_prep.sv
rtl/e2q_cordic_cell.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion.sv
tb/euler_to_quaternion_tb.sv
